/* rtl/core/sqos_pkg.sv */
// ----------------------------------------------------------------------------
// Sample quartile outlier statistics: shared package
// Sizes, code values, state and control types used by the whole block.
// ----------------------------------------------------------------------------
package sqos_pkg;

    // Capacity and sample size.
    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;

    // Derived widths.
    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_BITS + IDX_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + IDX_W;
    localparam int ARITH_W = 64;
    localparam int STEP_W  = $clog2(ARITH_W);
    localparam int DV_W    = 2 * CNT_W;
    localparam int FENCE_W = SAMPLE_BITS + 4;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 20;

    // Reciprocal of ten for the decile index.
    localparam int TEN_SHIFT = CNT_W + 4;
    localparam int TEN_MUL   = (2 ** TEN_SHIFT) / 10 + 1;
    localparam int TEN_W     = CNT_W + TEN_SHIFT;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_W-1:0]       t_count;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_MEAN   = 4'd0,
        KIND_STDEV  = 4'd1,
        KIND_MIN    = 4'd2,
        KIND_P10    = 4'd3,
        KIND_P25    = 4'd4,
        KIND_MEDIAN = 4'd5,
        KIND_P75    = 4'd6,
        KIND_P90    = 4'd7,
        KIND_MAX    = 4'd8,
        KIND_LOW    = 4'd9,
        KIND_HIGH   = 4'd10,
        KIND_COUNT  = 4'd11,
        KIND_ERROR  = 4'd12
    } t_kind;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_ERR,
        S_SCAN1,
        S_FENCE,
        S_SCAN2,
        S_MUL_NQ,
        S_MUL_SS,
        S_MUL_NN,
        S_DIV_MEAN,
        S_DIV_VAR,
        S_SQRT,
        S_EMIT
    } t_state;

    // Control broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic    ins;
        logic    rot;
        t_sample x;
        t_count  count;
    } t_chain_ctrl;

endpackage

/* rtl/core/sqos_in_if.sv */
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one sample word and its last flag.
// ----------------------------------------------------------------------------
interface sqos_in_if;
    logic                 valid;
    logic                 ready;
    sqos_pkg::t_sample    sample;
    logic                 last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/core/sqos_out_if.sv */
// ----------------------------------------------------------------------------
// Statistics output channel
// Valid/ready channel carrying one statistics result word.
// ----------------------------------------------------------------------------
interface sqos_out_if;
    logic                              valid;
    logic                              ready;
    logic [sqos_pkg::KIND_W-1:0]       stat_kind;
    logic [sqos_pkg::VALUE_W-1:0]      stat_value;
    logic                              present;
    logic                              last_of_run;

    modport source (output valid, output stat_kind, output stat_value,
                    output present, output last_of_run, input ready);
    modport sink   (input valid, input stat_kind, input stat_value,
                    input present, input last_of_run, output ready);
endinterface

/* rtl/core/sqos_cell.sv */
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one sorted sample; inserts by shifting up, rotates down on scans.
// ----------------------------------------------------------------------------
module sqos_cell (
    input  logic                  i_clk,
    input  sqos_pkg::t_chain_ctrl i_ctrl,
    input  logic                  i_occ,
    input  sqos_pkg::t_sample     i_prev_val,
    input  logic                  i_prev_gt,
    input  sqos_pkg::t_sample     i_next_val,
    output sqos_pkg::t_sample     o_val,
    output logic                  o_gt
);

    sqos_pkg::t_sample r_val;

    // An empty cell counts as holding a value above any new sample.
    assign o_gt  = i_occ ? (r_val > i_ctrl.x) : 1'b1;
    assign o_val = r_val;

    // Insert: take the lower neighbor's value or the new word; scan: rotate.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (i_prev_gt) begin
                r_val <= i_prev_val;
            end else if (o_gt) begin
                r_val <= i_ctrl.x;
            end
        end else if (i_ctrl.rot) begin
            r_val <= i_next_val;
        end
    end

endmodule

/* rtl/core/sqos_chain.sv */
// ----------------------------------------------------------------------------
// Sorting chain
// A row of sorting cells; cell zero always holds the smallest or head word.
// ----------------------------------------------------------------------------
module sqos_chain (
    input  logic                  i_clk,
    input  sqos_pkg::t_chain_ctrl i_ctrl,
    output sqos_pkg::t_sample     o_head
);

    sqos_pkg::t_sample          w_val [sqos_pkg::MAX_SAMPLES];
    logic [sqos_pkg::MAX_SAMPLES-1:0] w_gt;

    // Each cell sees its lower neighbor for inserts and its upper one for scans.
    for (genvar i = 0; i < sqos_pkg::MAX_SAMPLES; i++) begin : g_cell
        logic              w_occ;
        sqos_pkg::t_sample w_prev_val;
        logic              w_prev_gt;

        assign w_occ = sqos_pkg::CNT_W'(i) < i_ctrl.count;

        if (i == 0) begin : g_first
            assign w_prev_val = '0;
            assign w_prev_gt  = 1'b0;
        end else begin : g_rest
            assign w_prev_val = w_val[i-1];
            assign w_prev_gt  = w_gt[i-1];
        end

        sqos_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_occ      (w_occ),
            .i_prev_val (w_prev_val),
            .i_prev_gt  (w_prev_gt),
            .i_next_val (w_val[(i + 1) % sqos_pkg::MAX_SAMPLES]),
            .o_val      (w_val[i]),
            .o_gt       (w_gt[i])
        );
    end

    assign o_head = w_val[0];

endmodule

/* rtl/core/sample_quartile_outlier_stats.sv */
// ----------------------------------------------------------------------------
// Sample quartile outlier statistics
// Sorted sample set with mean, deviation, percentiles and Tukey outliers.
// ----------------------------------------------------------------------------
// Samples enter at one word per cycle while the set is loading, into a chain
// of 1024 sorting cells, which keeps them in ascending order; words past 1024
// are dropped. The word flagged last closes the set: the chain is rotated
// through twice (first to pick up the order statistics, then to count the
// outliers), then three shift-add multiplies, two restoring divides and a
// square root produce the mean and deviation, and the twelve result words
// follow, one per cycle as the sink takes them. A set of fewer than four
// samples gives a single error word instead. No sample is taken while a run
// is being worked out.

module sample_quartile_outlier_stats (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sqos_in_if.sink         i_in,
    sqos_out_if.source      o_out
);

    localparam int SB = sqos_pkg::SAMPLE_BITS;
    localparam int AW = sqos_pkg::ARITH_W;
    localparam int FW = sqos_pkg::FENCE_W;
    localparam int CW = sqos_pkg::CNT_W;

    sqos_pkg::t_state r_state, n_state;

    sqos_pkg::t_count               r_count;
    logic [sqos_pkg::SUM_W-1:0]     r_sum;
    logic [sqos_pkg::SQ_W-1:0]      r_sq;
    logic [sqos_pkg::IDX_W-1:0]     r_k;
    logic [sqos_pkg::STEP_W-1:0]    r_step;
    sqos_pkg::t_kind                r_emit_kind;
    logic                           r_o_valid;

    // Datapath registers.
    sqos_pkg::t_sample r_min, r_max, r_p10, r_p90;
    sqos_pkg::t_sample r_q1a, r_q1b, r_mda, r_mdb, r_q3a, r_q3b;
    logic signed [FW-1:0] r_lo2, r_hi2;
    sqos_pkg::t_count r_lo_cnt, r_hi_cnt;
    logic [AW-1:0] r_mc, r_acc, r_nq, r_ss, r_dq, r_sx, r_root, r_bit;
    logic [sqos_pkg::SUM_W-1:0] r_mp;
    logic [sqos_pkg::DV_W-1:0]  r_nn, r_dv, r_rem;
    logic [sqos_pkg::VALUE_W-1:0] r_mean, r_stdev;
    logic [sqos_pkg::KIND_W-1:0]  r_o_kind;
    logic [sqos_pkg::VALUE_W-1:0] r_o_value;
    logic r_o_present, r_o_last;

    logic in_acc, out_free, scan_done, mul_done, div_done, sqrt_done;
    sqos_pkg::t_chain_ctrl w_ctrl;
    sqos_pkg::t_sample     w_head;
    logic [2*SB-1:0]       w_sq_in;

    // Handshakes and iteration ends.
    assign in_acc    = i_in.valid && i_in.ready;
    assign out_free  = !r_o_valid || o_out.ready;
    assign scan_done = r_k == sqos_pkg::IDX_W'(sqos_pkg::MAX_SAMPLES - 1);
    assign mul_done  = r_step == sqos_pkg::STEP_W'(sqos_pkg::SUM_W - 1);
    assign div_done  = r_step == sqos_pkg::STEP_W'(AW - 1);
    assign sqrt_done = r_step == sqos_pkg::STEP_W'(AW / 2 - 1);

    assign i_in.ready        = r_state == sqos_pkg::S_LOAD;
    assign o_out.valid       = r_o_valid;
    assign o_out.stat_kind   = r_o_kind;
    assign o_out.stat_value  = r_o_value;
    assign o_out.present     = r_o_present;
    assign o_out.last_of_run = r_o_last;

    // Square of the incoming sample at full width.
    assign w_sq_in = {{SB{1'b0}}, i_in.sample} * {{SB{1'b0}}, i_in.sample};

    // Sorting chain.
    assign w_ctrl.ins   = in_acc && (r_count < CW'(sqos_pkg::MAX_SAMPLES));
    assign w_ctrl.rot   = (r_state == sqos_pkg::S_SCAN1) || (r_state == sqos_pkg::S_SCAN2);
    assign w_ctrl.x     = i_in.sample;
    assign w_ctrl.count = r_count;

    sqos_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .o_head (w_head)
    );

    // Order statistic positions from the sample count.
    logic [sqos_pkg::TEN_W-1:0] w_ten_prod;
    sqos_pkg::t_count w_i10, w_i90, w_a25, w_m50, w_a75;
    logic w_big, w_split_q, w_split_m;

    assign w_ten_prod = sqos_pkg::TEN_W'(r_count) * sqos_pkg::TEN_W'(sqos_pkg::TEN_MUL);
    assign w_i10      = CW'(w_ten_prod >> sqos_pkg::TEN_SHIFT);
    assign w_i90      = r_count - w_i10;
    assign w_a25      = (r_count - CW'(2)) >> 2;
    assign w_m50      = (r_count - CW'(1)) >> 1;
    assign w_a75      = CW'((r_count >> 2) * CW'(3)) - CW'(1) + CW'(r_count[1:0]);
    assign w_big      = r_count >= CW'(10);
    assign w_split_q  = !r_count[1];
    assign w_split_m  = !r_count[0];

    // Quartiles and median, averaging split pairs.
    logic [SB:0] w_s25, w_s50, w_s75;
    sqos_pkg::t_sample w_p25, w_p50, w_p75;

    assign w_s25 = {1'b0, r_q1a} + {1'b0, r_q1b};
    assign w_s50 = {1'b0, r_mda} + {1'b0, r_mdb};
    assign w_s75 = {1'b0, r_q3a} + {1'b0, r_q3b};
    assign w_p25 = w_split_q ? w_s25[SB:1] : r_q1a;
    assign w_p50 = w_split_m ? w_s50[SB:1] : r_mda;
    assign w_p75 = w_split_q ? w_s75[SB:1] : r_q3a;

    // Doubled Tukey fences: 5*p25 - 3*p75 and 5*p75 - 3*p25.
    logic signed [FW-1:0] w_p25s, w_p75s, w_v2;
    assign w_p25s = $signed({{(FW - SB){1'b0}}, w_p25});
    assign w_p75s = $signed({{(FW - SB){1'b0}}, w_p75});
    assign w_v2   = $signed({{(FW - SB - 1){1'b0}}, w_head, 1'b0});

    // Shift-add multiply step.
    logic [AW-1:0] w_acc_nx;
    assign w_acc_nx = r_mp[0] ? r_acc + r_mc : r_acc;

    // Restoring divide step.
    logic [sqos_pkg::DV_W:0]   w_rem_sh;
    logic                      w_div_ge;
    logic [sqos_pkg::DV_W-1:0] w_rem_nx;
    logic [AW-1:0]             w_dq_nx;
    assign w_rem_sh = {r_rem, r_dq[AW-1]};
    assign w_div_ge = w_rem_sh >= {1'b0, r_dv};
    assign w_rem_nx = w_div_ge ? sqos_pkg::DV_W'(w_rem_sh - {1'b0, r_dv})
                               : sqos_pkg::DV_W'(w_rem_sh);
    assign w_dq_nx  = {r_dq[AW-2:0], w_div_ge};

    // Square root step, two bits of the operand per cycle.
    logic [AW-1:0] w_trial, w_root_nx, w_sx_nx;
    logic          w_sq_ge;
    assign w_trial   = r_root + r_bit;
    assign w_sq_ge   = r_sx >= w_trial;
    assign w_root_nx = w_sq_ge ? (r_root >> 1) + r_bit : r_root >> 1;
    assign w_sx_nx   = w_sq_ge ? r_sx - w_trial : r_sx;

    // Variance numerator n*Q - S*S.
    logic [AW-1:0] w_d;
    assign w_d = r_nq - r_ss;

    // Value of the result word being emitted.
    logic [sqos_pkg::VALUE_W-1:0] w_value;
    logic                         w_present;
    always_comb begin
        w_present = 1'b1;
        case (r_emit_kind)
            sqos_pkg::KIND_MEAN:   w_value = r_mean;
            sqos_pkg::KIND_STDEV:  w_value = r_stdev;
            sqos_pkg::KIND_MIN:    w_value = sqos_pkg::VALUE_W'(r_min);
            sqos_pkg::KIND_P10: begin
                w_value   = w_big ? sqos_pkg::VALUE_W'(r_p10) : '0;
                w_present = w_big;
            end
            sqos_pkg::KIND_P25:    w_value = sqos_pkg::VALUE_W'(w_p25);
            sqos_pkg::KIND_MEDIAN: w_value = sqos_pkg::VALUE_W'(w_p50);
            sqos_pkg::KIND_P75:    w_value = sqos_pkg::VALUE_W'(w_p75);
            sqos_pkg::KIND_P90: begin
                w_value   = w_big ? sqos_pkg::VALUE_W'(r_p90) : '0;
                w_present = w_big;
            end
            sqos_pkg::KIND_MAX:    w_value = sqos_pkg::VALUE_W'(r_max);
            sqos_pkg::KIND_LOW:    w_value = sqos_pkg::VALUE_W'(r_lo_cnt);
            sqos_pkg::KIND_HIGH:   w_value = sqos_pkg::VALUE_W'(r_hi_cnt);
            default:               w_value = sqos_pkg::VALUE_W'(r_count);
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqos_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sqos_pkg::S_LOAD:     if (in_acc && i_in.last) n_state = sqos_pkg::S_CHECK;
            sqos_pkg::S_CHECK: begin
                n_state = (r_count < CW'(4)) ? sqos_pkg::S_ERR : sqos_pkg::S_SCAN1;
            end
            sqos_pkg::S_ERR:      if (out_free) n_state = sqos_pkg::S_LOAD;
            sqos_pkg::S_SCAN1:    if (scan_done) n_state = sqos_pkg::S_FENCE;
            sqos_pkg::S_FENCE:    n_state = sqos_pkg::S_SCAN2;
            sqos_pkg::S_SCAN2:    if (scan_done) n_state = sqos_pkg::S_MUL_NQ;
            sqos_pkg::S_MUL_NQ:   if (mul_done) n_state = sqos_pkg::S_MUL_SS;
            sqos_pkg::S_MUL_SS:   if (mul_done) n_state = sqos_pkg::S_MUL_NN;
            sqos_pkg::S_MUL_NN:   if (mul_done) n_state = sqos_pkg::S_DIV_MEAN;
            sqos_pkg::S_DIV_MEAN: if (div_done) n_state = sqos_pkg::S_DIV_VAR;
            sqos_pkg::S_DIV_VAR:  if (div_done) n_state = sqos_pkg::S_SQRT;
            sqos_pkg::S_SQRT:     if (sqrt_done) n_state = sqos_pkg::S_EMIT;
            sqos_pkg::S_EMIT: begin
                if (out_free && (r_emit_kind == sqos_pkg::KIND_COUNT)) begin
                    n_state = sqos_pkg::S_LOAD;
                end
            end
            default:              n_state = sqos_pkg::S_LOAD;
        endcase
    end

    // Set totals, counters and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_k         <= '0;
            r_step      <= '0;
            r_emit_kind <= sqos_pkg::KIND_MEAN;
            r_o_valid   <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_ctrl.ins) begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + sqos_pkg::SUM_W'(i_in.sample);
                r_sq    <= r_sq + sqos_pkg::SQ_W'(w_sq_in);
            end
            // The scan position wraps to zero after the last cell.
            if (w_ctrl.rot) begin
                r_k <= scan_done ? '0 : r_k + sqos_pkg::IDX_W'(1);
            end
            case (r_state)
                sqos_pkg::S_MUL_NQ, sqos_pkg::S_MUL_SS, sqos_pkg::S_MUL_NN: begin
                    r_step <= mul_done ? '0 : r_step + sqos_pkg::STEP_W'(1);
                end
                sqos_pkg::S_DIV_MEAN, sqos_pkg::S_DIV_VAR, sqos_pkg::S_SQRT: begin
                    r_step <= (div_done || sqrt_done) && (r_state == sqos_pkg::S_SQRT ?
                              sqrt_done : div_done) ? '0 : r_step + sqos_pkg::STEP_W'(1);
                end
                default: r_step <= '0;
            endcase
            // A finished run empties the set.
            if ((r_state == sqos_pkg::S_ERR) && out_free) begin
                r_o_valid <= 1'b1;
                r_count   <= '0;
                r_sum     <= '0;
                r_sq      <= '0;
            end
            if ((r_state == sqos_pkg::S_EMIT) && out_free) begin
                r_o_valid <= 1'b1;
                if (r_emit_kind == sqos_pkg::KIND_COUNT) begin
                    r_emit_kind <= sqos_pkg::KIND_MEAN;
                    r_count     <= '0;
                    r_sum       <= '0;
                    r_sq        <= '0;
                end else begin
                    r_emit_kind <= sqos_pkg::t_kind'(r_emit_kind + sqos_pkg::KIND_W'(1));
                end
            end
        end
    end

    // Scan captures, arithmetic units and the output word.
    always_ff @(posedge i_clk) begin
        case (r_state)
            sqos_pkg::S_CHECK: begin
                r_lo_cnt <= '0;
                r_hi_cnt <= '0;
            end
            sqos_pkg::S_ERR: begin
                if (out_free) begin
                    r_o_kind    <= sqos_pkg::KIND_ERROR;
                    r_o_value   <= sqos_pkg::VALUE_W'(r_count);
                    r_o_present <= 1'b1;
                    r_o_last    <= 1'b1;
                end
            end
            sqos_pkg::S_SCAN1: begin
                if (r_k == '0) r_min <= w_head;
                if (CW'(r_k) == r_count - CW'(1)) r_max <= w_head;
                if (CW'(r_k) == w_i10) r_p10 <= w_head;
                if (CW'(r_k) == w_i90) r_p90 <= w_head;
                if (CW'(r_k) == w_a25) r_q1a <= w_head;
                if (CW'(r_k) == w_a25 + CW'(1)) r_q1b <= w_head;
                if (CW'(r_k) == w_m50) r_mda <= w_head;
                if (CW'(r_k) == w_m50 + CW'(1)) r_mdb <= w_head;
                if (CW'(r_k) == w_a75) r_q3a <= w_head;
                if (CW'(r_k) == w_a75 + CW'(1)) r_q3b <= w_head;
            end
            sqos_pkg::S_FENCE: begin
                r_lo2 <= (w_p25s <<< 2) + w_p25s - ((w_p75s <<< 1) + w_p75s);
                r_hi2 <= (w_p75s <<< 2) + w_p75s - ((w_p25s <<< 1) + w_p25s);
            end
            sqos_pkg::S_SCAN2: begin
                if (CW'(r_k) < r_count) begin
                    if (w_v2 < r_lo2) r_lo_cnt <= r_lo_cnt + CW'(1);
                    if (w_v2 > r_hi2) r_hi_cnt <= r_hi_cnt + CW'(1);
                end
                // Load the first multiply: n * Q.
                r_mc  <= AW'(r_sq);
                r_mp  <= sqos_pkg::SUM_W'(r_count);
                r_acc <= '0;
            end
            sqos_pkg::S_MUL_NQ, sqos_pkg::S_MUL_SS, sqos_pkg::S_MUL_NN: begin
                r_acc <= w_acc_nx;
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                if (mul_done) begin
                    r_acc <= '0;
                    if (r_state == sqos_pkg::S_MUL_NQ) begin
                        r_nq <= w_acc_nx;
                        r_mc <= AW'(r_sum);
                        r_mp <= r_sum;
                    end else if (r_state == sqos_pkg::S_MUL_SS) begin
                        r_ss <= w_acc_nx;
                        r_mc <= AW'(r_count);
                        r_mp <= sqos_pkg::SUM_W'(r_count);
                    end else begin
                        // Load the mean divide: 16 * S / n.
                        r_nn  <= sqos_pkg::DV_W'(w_acc_nx);
                        r_dq  <= AW'({r_sum, 4'b0000});
                        r_dv  <= sqos_pkg::DV_W'(r_count);
                        r_rem <= '0;
                    end
                end
            end
            sqos_pkg::S_DIV_MEAN: begin
                r_dq  <= w_dq_nx;
                r_rem <= w_rem_nx;
                if (div_done) begin
                    // Load the variance divide: 256 * d / n^2.
                    r_mean <= w_dq_nx[sqos_pkg::VALUE_W-1:0];
                    r_dq   <= {w_d[AW-9:0], 8'h00};
                    r_dv   <= r_nn;
                    r_rem  <= '0;
                end
            end
            sqos_pkg::S_DIV_VAR: begin
                r_dq  <= w_dq_nx;
                r_rem <= w_rem_nx;
                if (div_done) begin
                    r_sx   <= w_dq_nx;
                    r_root <= '0;
                    r_bit  <= AW'(1) << (AW - 2);
                end
            end
            sqos_pkg::S_SQRT: begin
                r_sx   <= w_sx_nx;
                r_root <= w_root_nx;
                r_bit  <= r_bit >> 2;
                if (sqrt_done) begin
                    r_stdev <= w_root_nx[sqos_pkg::VALUE_W-1:0];
                end
            end
            sqos_pkg::S_EMIT: begin
                if (out_free) begin
                    r_o_kind    <= r_emit_kind;
                    r_o_value   <= w_value;
                    r_o_present <= w_present;
                    r_o_last    <= r_emit_kind == sqos_pkg::KIND_COUNT;
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule
